>>> hdl/gwm_pkg.sv
package gwm_pkg;

  localparam int PATTERN_CHARS = 32;
  // Live positions run from 0 (nothing matched) up to PATTERN_CHARS.
  localparam int POS_W = PATTERN_CHARS + 1;
  localparam int LEN_W = $clog2(PATTERN_CHARS + 1);
  // Prefix levels for the star closure over POS_W positions.
  localparam int CLOSE_LEVELS = $clog2(POS_W);

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;
  localparam logic [7:0] END_CHAR  = 8'h00;

  // Register map, 64-bit registers at 8-byte strides.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd4;

  localparam int CHARS_PER_REG = 8;

  // Pattern as seen by the matcher: bytes plus the clamped length in use.
  typedef struct packed {
    logic [PATTERN_CHARS-1:0][7:0] chars;
    logic [LEN_W-1:0]              len;
  } gwm_pattern_t;

endpackage

>>> hdl/gwm_regs.sv
module gwm_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gwm_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [gwm_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output gwm_pkg::gwm_pattern_t               pattern
);

  logic [3:0][gwm_pkg::CFG_DATA_W-1:0] pat_words_r;
  logic [gwm_pkg::LEN_W-1:0]           pat_len_r;
  logic                                wr_en;
  logic [gwm_pkg::REG_IDX_W-1:0]       reg_idx;

  assign reg_idx = cfg_paddr[gwm_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r <= '0;
      pat_len_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        gwm_pkg::REG_PAT0: pat_words_r[0] <= cfg_pwdata;
        gwm_pkg::REG_PAT1: pat_words_r[1] <= cfg_pwdata;
        gwm_pkg::REG_PAT2: pat_words_r[2] <= cfg_pwdata;
        gwm_pkg::REG_PAT3: pat_words_r[3] <= cfg_pwdata;
        gwm_pkg::REG_LEN:  pat_len_r      <= cfg_pwdata[gwm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gwm_pkg::REG_PAT0: cfg_prdata = pat_words_r[0];
      gwm_pkg::REG_PAT1: cfg_prdata = pat_words_r[1];
      gwm_pkg::REG_PAT2: cfg_prdata = pat_words_r[2];
      gwm_pkg::REG_PAT3: cfg_prdata = pat_words_r[3];
      gwm_pkg::REG_LEN:  cfg_prdata = gwm_pkg::CFG_DATA_W'(pat_len_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // Byte i of the pattern sits in word i/8 at bits 8*(i%8); lengths past
  // the pattern store clamp to its size.
  always_comb begin
    for (int i = 0; i < gwm_pkg::PATTERN_CHARS; i++) begin
      pattern.chars[i] = pat_words_r[i / gwm_pkg::CHARS_PER_REG]
                                    [(i % gwm_pkg::CHARS_PER_REG) * 8 +: 8];
    end
    if (pat_len_r > gwm_pkg::LEN_W'(gwm_pkg::PATTERN_CHARS)) begin
      pattern.len = gwm_pkg::LEN_W'(gwm_pkg::PATTERN_CHARS);
    end else begin
      pattern.len = pat_len_r;
    end
  end

endmodule

>>> hdl/gwm_nfa.sv
module gwm_nfa (
  input  gwm_pkg::gwm_pattern_t          pattern,
  input  logic [gwm_pkg::POS_W-1:0]      live,
  input  logic [7:0]                     text_byte,
  output logic [gwm_pkg::POS_W-1:0]      live_nxt,
  output logic                           matched
);

  localparam int L = gwm_pkg::CLOSE_LEVELS;

  logic [gwm_pkg::POS_W-1:0]      mask;
  logic [gwm_pkg::POS_W-1:0]      closed;
  logic [gwm_pkg::POS_W-1:0]      step;
  logic [L:0][gwm_pkg::POS_W-1:0] gen;
  logic [L:0][gwm_pkg::POS_W-1:0] prop;

  // Star closure as a parallel prefix: a live bit flows upward through
  // each run of '*' positions, like a carry through propagate bits.
  always_comb begin
    for (int j = 0; j < gwm_pkg::POS_W; j++) begin
      mask[j] = (gwm_pkg::LEN_W'(j) <= pattern.len) || (j == 0);
    end
    gen[0]     = live & mask;
    prop[0][0] = 1'b0;
    for (int j = 1; j < gwm_pkg::POS_W; j++) begin
      prop[0][j] = (gwm_pkg::LEN_W'(j - 1) < pattern.len) &&
                   (pattern.chars[j-1] == gwm_pkg::STAR_CHAR);
    end
    for (int l = 0; l < L; l++) begin
      for (int j = 0; j < gwm_pkg::POS_W; j++) begin
        if (j >= (1 << l)) begin
          gen[l+1][j]  = gen[l][j] | (prop[l][j] & gen[l][j - (1 << l)]);
          prop[l+1][j] = prop[l][j] & prop[l][j - (1 << l)];
        end else begin
          gen[l+1][j]  = gen[l][j];
          prop[l+1][j] = 1'b0;
        end
      end
    end
    closed = gen[L];
  end

  // One text byte: '*' stays put, '?' or an equal nonzero byte advances.
  always_comb begin
    step = '0;
    for (int i = 0; i < gwm_pkg::PATTERN_CHARS; i++) begin
      if (closed[i] && (gwm_pkg::LEN_W'(i) < pattern.len)) begin
        if (pattern.chars[i] == gwm_pkg::STAR_CHAR) begin
          step[i] = 1'b1;
        end else if ((pattern.chars[i] == gwm_pkg::ANY_CHAR) ||
                     ((pattern.chars[i] != gwm_pkg::END_CHAR) &&
                      (pattern.chars[i] == text_byte))) begin
          step[i+1] = 1'b1;
        end
      end
    end
  end

  assign matched  = closed[pattern.len];
  assign live_nxt = (text_byte == gwm_pkg::END_CHAR) ? gwm_pkg::POS_W'(1) : step;

endmodule

>>> hdl/wildcard_glob_matcher_unit.sv
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   in_tdata[7:0]  = text_byte
// out_     out  out_tvalid/out_tready out_tdata[7:0] = {7'b0, matched}
// cfg_     in   APB, pready tied high 64-bit pattern words, pattern_length
//
// One text byte per cycle sustained while no zero byte waits on out_. Each item
// is held in the input register; the live-position update (star closure prefix
// plus one match step) is the logic between it and the live/result registers.
// A zero byte yields one item on out_, registered in the result register once
// it leaves the input register; other bytes yield nothing. Reset (rst_n low,
// synchronous) empties both registers and sets live position zero; the pattern
// resets to empty. When out_ stalls with a result pending, non-zero bytes keep
// flowing and only a following zero byte waits in the input register.
module wildcard_glob_matcher_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [7:0] text_byte
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  // out_tdata: [0] matched, [7:1] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [gwm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gwm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  gwm_pkg::gwm_pattern_t         pattern;
  logic                          s1_valid_r;
  logic [7:0]                    s1_byte_r;
  logic [gwm_pkg::POS_W-1:0]     live_r;
  logic [gwm_pkg::POS_W-1:0]     live_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_matched_r;
  logic                          matched;
  logic                          s1_end;
  logic                          s1_adv;
  logic                          out_free;

  assign cfg_pready = 1'b1;

  gwm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .pattern     (pattern)
  );

  gwm_nfa u_nfa (
    .pattern   (pattern),
    .live      (live_r),
    .text_byte (s1_byte_r),
    .live_nxt  (live_nxt),
    .matched   (matched)
  );

  // End-of-string bytes need a free result register; others always move on.
  assign s1_end    = (s1_byte_r == gwm_pkg::END_CHAR);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_end || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_valid_nxt = (out_valid_r && !out_tready) || (s1_adv && s1_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      live_r      <= gwm_pkg::POS_W'(1);
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        live_r <= live_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_adv && s1_end) begin
      out_matched_r <= matched;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_matched_r};

endmodule
